@@ rtl/core/utf8_byte_stream_decoder_core_macros.svh @@
// Assertion macros shared by the UTF-8 decoder checker.
// Depends on nothing; included by files that carry concurrent assertions.
`ifndef UTF8_BYTE_STREAM_DECODER_CORE_MACROS_SVH
`define UTF8_BYTE_STREAM_DECODER_CORE_MACROS_SVH

// Same-cycle implication, disabled during reset
`define U8DEC_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled during reset
`define U8DEC_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

@@ rtl/core/u8dec_pkg.sv @@
// Shared types and constants for the UTF-8 byte stream decoder.
// No dependencies; used by the core and its checker.
package u8dec_pkg;

   localparam int unsigned BYTE_W  = 8;
   localparam int unsigned CP_W    = 21;
   localparam int unsigned CP_PAD_W = 24;
   localparam int unsigned STAT_W  = 2;
   localparam int unsigned REM_W   = 2;

   // Result status codes
   typedef enum logic [STAT_W-1:0] {
      ST_OK        = 2'd0,
      ST_MALFORMED = 2'd1,
      ST_ABORT     = 2'd2,
      ST_TRUNCATED = 2'd3
   } status_type;

endpackage

@@ rtl/core/utf8_byte_stream_decoder_core.sv @@
// UTF-8 byte stream decoder: byte requests in, code point results out.
// Depends on u8dec_pkg.
//
// Usage:
//   req channel: one byte of a UTF-8 string per request in req_tdata,
//     req_tlast marks the final byte of the string.
//   rsp channel: one result per completed character, stray continuation
//     abort or truncated string end. rsp_tdata carries the code point,
//     rsp_tuser the status (ok, malformed, abort, truncated), rsp_tlast
//     marks the result that ends the string's conversion.
//   Lead bytes and continuation bytes inside a sequence give no result,
//     nor do bytes dropped after an abort up to the string's last byte.
// Timing:
//   A request is registered, then decoded by one level of logic into the
//   result register. One byte is taken per cycle unless a byte that gives
//   a result waits on a stalled receiver; the decode state (remaining count,
//   accumulator, error flags) updates in the same cycle it is consumed.
// Reset clears the pipeline valids and the decode state. When the receiver
// stalls, the result register holds and the input register fills; bytes that
// give no result keep flowing past a stalled result.
module utf8_byte_stream_decoder_core (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] data_byte
   input  logic        req_tlast,   // is_last_byte
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,   // [20:0] code_point, [23:21] zero
   output logic [1:0]  rsp_tuser,   // [1:0] status
   output logic        rsp_tlast    // end_of_string
);

   // input register
   logic                         in_vld_ff;
   logic [u8dec_pkg::BYTE_W-1:0] in_byte_ff;
   logic                         in_last_ff;

   // decode state
   logic [u8dec_pkg::REM_W-1:0]  rem_ff, rem_in;
   logic [u8dec_pkg::CP_W-1:0]   acc_ff, acc_in;
   logic                         bad_ff, bad_in;
   logic                         disc_ff, disc_in;

   // result register
   logic                         out_vld_ff;
   logic [u8dec_pkg::CP_W-1:0]   out_cp_ff, out_cp_in;
   u8dec_pkg::status_type        out_st_ff, out_st_in;
   logic                         out_eos_ff, out_eos_in;

   logic                         has_result;
   logic                         in_adv;
   logic                         out_free;
   logic [u8dec_pkg::REM_W-1:0]  rem_dec;
   logic [u8dec_pkg::CP_W-1:0]   acc_shift;

   assign out_free   = !out_vld_ff || rsp_tready;
   assign in_adv     = in_vld_ff && (out_free || !has_result);
   assign req_tready = !in_vld_ff || in_adv;

   assign rem_dec   = rem_ff - u8dec_pkg::REM_W'(1);
   assign acc_shift = {acc_ff[u8dec_pkg::CP_W-7:0], in_byte_ff[5:0]};

   // decode one byte against the current sequence state
   always_comb begin
      rem_in     = rem_ff;
      acc_in     = acc_ff;
      bad_in     = bad_ff;
      disc_in    = disc_ff;
      has_result = 1'b0;
      out_cp_in  = '0;
      out_st_in  = u8dec_pkg::ST_OK;
      out_eos_in = in_last_ff;
      if (disc_ff) begin
         // drop bytes until the string's last byte
         if (in_last_ff) begin
            disc_in = 1'b0;
            rem_in  = '0;
            acc_in  = '0;
            bad_in  = 1'b0;
         end
      end else if (rem_ff == '0) begin
         if (!in_byte_ff[7]) begin
            // single-byte character
            has_result = 1'b1;
            out_cp_in  = u8dec_pkg::CP_W'(in_byte_ff);
         end else if (!in_byte_ff[6]) begin
            // stray continuation: abort the string
            has_result = 1'b1;
            out_st_in  = u8dec_pkg::ST_ABORT;
            out_eos_in = 1'b1;
            disc_in    = !in_last_ff;
            rem_in     = '0;
            acc_in     = '0;
            bad_in     = 1'b0;
         end else begin
            // lead byte: load payload bits and length
            priority if (in_byte_ff[5:4] == 2'b11) begin
               rem_in = 2'd3;
               bad_in = in_byte_ff[3];
               acc_in = in_byte_ff[3] ? '0 : u8dec_pkg::CP_W'(in_byte_ff[2:0]);
            end else if (in_byte_ff[5]) begin
               rem_in = 2'd2;
               bad_in = 1'b0;
               acc_in = u8dec_pkg::CP_W'(in_byte_ff[3:0]);
            end else begin
               rem_in = 2'd1;
               bad_in = 1'b0;
               acc_in = u8dec_pkg::CP_W'(in_byte_ff[4:0]);
            end
            if (in_last_ff) begin
               has_result = 1'b1;
               out_st_in  = u8dec_pkg::ST_TRUNCATED;
               out_eos_in = 1'b1;
               rem_in     = '0;
               acc_in     = '0;
               bad_in     = 1'b0;
            end
         end
      end else begin
         // continuation position inside a sequence
         if (in_byte_ff[7:6] == 2'b10) begin
            acc_in = acc_shift;
         end else begin
            bad_in = 1'b1;
         end
         rem_in = rem_dec;
         if (rem_dec == '0) begin
            has_result = 1'b1;
            out_cp_in  = bad_in ? '0 : acc_in;
            out_st_in  = bad_in ? u8dec_pkg::ST_MALFORMED : u8dec_pkg::ST_OK;
            acc_in     = '0;
            bad_in     = 1'b0;
         end else if (in_last_ff) begin
            has_result = 1'b1;
            out_st_in  = u8dec_pkg::ST_TRUNCATED;
            out_eos_in = 1'b1;
            rem_in     = '0;
            acc_in     = '0;
            bad_in     = 1'b0;
         end
      end
   end

   // input register: take a request when empty or draining
   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff <= 1'b0;
      end else if (req_tready) begin
         in_vld_ff <= req_tvalid;
      end
      if (req_tready && req_tvalid) begin
         in_byte_ff <= req_tdata;
         in_last_ff <= req_tlast;
      end
   end

   // decode state: advance when the registered byte is consumed
   always_ff @(posedge clock) begin
      if (reset) begin
         rem_ff  <= '0;
         acc_ff  <= '0;
         bad_ff  <= 1'b0;
         disc_ff <= 1'b0;
      end else if (in_adv) begin
         rem_ff  <= rem_in;
         acc_ff  <= acc_in;
         bad_ff  <= bad_in;
         disc_ff <= disc_in;
      end
   end

   // result register: load on a result, drop when taken
   always_ff @(posedge clock) begin
      if (reset) begin
         out_vld_ff <= 1'b0;
      end else if (in_adv && has_result) begin
         out_vld_ff <= 1'b1;
      end else if (rsp_tready) begin
         out_vld_ff <= 1'b0;
      end
      if (in_adv && has_result) begin
         out_cp_ff  <= out_cp_in;
         out_st_ff  <= out_st_in;
         out_eos_ff <= out_eos_in;
      end
   end

   assign rsp_tvalid = out_vld_ff;
   assign rsp_tdata  = u8dec_pkg::CP_PAD_W'(out_cp_ff);
   assign rsp_tuser  = out_st_ff;
   assign rsp_tlast  = out_eos_ff;

endmodule

@@ rtl/core/u8dec_checker.sv @@
// Port-level checker for the UTF-8 decoder core, bound into the core module.
// Depends on u8dec_pkg and utf8_byte_stream_decoder_core_macros.svh.
`include "utf8_byte_stream_decoder_core_macros.svh"

module u8dec_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic [7:0]  req_tdata,
   input logic        req_tlast,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [23:0] rsp_tdata,
   input logic [1:0]  rsp_tuser,
   input logic        rsp_tlast
);

   // hold a stalled result
   `U8DEC_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser) && $stable(rsp_tlast), "stalled result changed")

   // error results carry a zero code point
   `U8DEC_ASSERT_NOW(a_err_zero, clock, reset, rsp_tvalid && (rsp_tuser != u8dec_pkg::ST_OK), rsp_tdata[20:0] == 21'd0, "error result with nonzero code point")

   // abort and truncation always end the string
   `U8DEC_ASSERT_NOW(a_err_eos, clock, reset, rsp_tvalid && ((rsp_tuser == u8dec_pkg::ST_ABORT) || (rsp_tuser == u8dec_pkg::ST_TRUNCATED)), rsp_tlast, "abort or truncation without end of string")

   // pad bits stay clear
   `U8DEC_ASSERT_NOW(a_pad_zero, clock, reset, rsp_tvalid, rsp_tdata[23:21] == 3'd0, "nonzero pad bits in result")

   // no result right after reset
   `U8DEC_ASSERT_NOW(a_rst_idle, clock, reset, $past(reset), !rsp_tvalid, "result valid right after reset")

endmodule

bind utf8_byte_stream_decoder_core u8dec_checker u_u8dec_checker (.*);

@@ bench/utf8_decode_checker.sv @@
`timescale 1ns / 100ps
// Checker for the UTF-8 byte stream decoder: decodes every accepted request byte
// on its own and compares each accepted result against the oldest one due.
// Depends on u8dec_pkg for field widths and status codes.
module utf8_decode_checker (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_tvalid,
   input  logic                           req_tready,
   input  logic [7:0]                     req_tdata,   // [7:0] data_byte
   input  logic                           req_tlast,   // is_last_byte
   input  logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   input  logic [u8dec_pkg::CP_PAD_W-1:0] rsp_tdata,   // [20:0] code_point, [23:21] zero
   input  logic [u8dec_pkg::STAT_W-1:0]   rsp_tuser,   // [1:0] status
   input  logic                           rsp_tlast,   // end_of_string
   output int                             mismatch_count,
   output int                             results_due
);

   typedef struct packed {
      logic [u8dec_pkg::CP_W-1:0] code_point;
      u8dec_pkg::status_type      status;
      logic                       end_of_string;
   } decoded_char_type;

   // Characters predicted but not yet seen on the result channel
   decoded_char_type chars_due[$];

   // Decode state of the predictor
   logic [u8dec_pkg::REM_W-1:0] cont_left;
   logic [u8dec_pkg::CP_W-1:0]  payload;
   logic                        seq_bad;
   logic                        dropping;
   int                          mismatches = 0;

   task automatic report_mismatch(input string msg);
      mismatches++;
      if (mismatches <= 100) begin
         $display("mismatch at %0t ns: %s", $time, msg);
      end
   endtask

   task automatic push_char(input logic [u8dec_pkg::CP_W-1:0] cp,
                            input u8dec_pkg::status_type st, input logic eos);
      decoded_char_type c;
      c.code_point = cp;
      c.status = st;
      c.end_of_string = eos;
      chars_due.push_back(c);
   endtask

   task automatic clear_sequence();
      cont_left = '0;
      payload = '0;
      seq_bad = 1'b0;
   endtask

   // Advance the decode state by one byte and queue the character it completes
   task automatic decode_byte(input logic [7:0] b, input logic last);
      if (dropping) begin
         // drop everything after an abort, up to the string's last byte
         if (last) begin
            dropping = 1'b0;
            clear_sequence();
         end
      end else if (cont_left == 0) begin
         if (!b[7]) begin
            push_char({{(u8dec_pkg::CP_W-8){1'b0}}, b}, u8dec_pkg::ST_OK, last);
         end else if (b[7:6] == 2'b10) begin
            // stray continuation where a lead byte belongs
            clear_sequence();
            dropping = !last;
            push_char('0, u8dec_pkg::ST_ABORT, 1'b1);
         end else begin
            seq_bad = 1'b0;
            if (b[7:4] == 4'hF) begin
               // F8 to FF still take four bytes but are flagged bad
               if (b[3]) begin
                  seq_bad = 1'b1;
                  payload = '0;
               end else begin
                  payload = {{(u8dec_pkg::CP_W-3){1'b0}}, b[2:0]};
               end
               cont_left = 2'd3;
            end else if (b[7:5] == 3'b111) begin
               payload = {{(u8dec_pkg::CP_W-4){1'b0}}, b[3:0]};
               cont_left = 2'd2;
            end else begin
               payload = {{(u8dec_pkg::CP_W-5){1'b0}}, b[4:0]};
               cont_left = 2'd1;
            end
            if (last) begin
               clear_sequence();
               push_char('0, u8dec_pkg::ST_TRUNCATED, 1'b1);
            end
         end
      end else begin
         // continuation position: a wrong byte still counts toward the length
         if (b[7:6] == 2'b10) begin
            payload = {payload[u8dec_pkg::CP_W-7:0], b[5:0]};
         end else begin
            seq_bad = 1'b1;
         end
         cont_left = cont_left - 2'd1;
         if (cont_left == 0) begin
            push_char(seq_bad ? '0 : payload,
                      seq_bad ? u8dec_pkg::ST_MALFORMED : u8dec_pkg::ST_OK, last);
            clear_sequence();
         end else if (last) begin
            clear_sequence();
            push_char('0, u8dec_pkg::ST_TRUNCATED, 1'b1);
         end
      end
   endtask

   // Predict on each accepted request, compare each accepted result
   always @(posedge clock) begin
      decoded_char_type want;
      if (reset) begin
         clear_sequence();
         dropping = 1'b0;
         chars_due.delete();
      end else begin
         if (req_tvalid && req_tready) begin
            decode_byte(req_tdata, req_tlast);
         end
         if (rsp_tvalid && rsp_tready) begin
            if (chars_due.size() == 0) begin
               report_mismatch($sformatf("unexpected result cp=%0h status=%0d last=%0b",
                                         rsp_tdata, rsp_tuser, rsp_tlast));
            end else begin
               want = chars_due.pop_front();
               if (rsp_tdata[u8dec_pkg::CP_W-1:0] !== want.code_point) begin
                  report_mismatch($sformatf("code point %0h, expected %0h",
                                            rsp_tdata[u8dec_pkg::CP_W-1:0],
                                            want.code_point));
               end
               if (rsp_tdata[u8dec_pkg::CP_PAD_W-1:u8dec_pkg::CP_W] !== '0) begin
                  report_mismatch($sformatf("padding bits %0b not zero",
                                            rsp_tdata[u8dec_pkg::CP_PAD_W-1:u8dec_pkg::CP_W]));
               end
               if (rsp_tuser !== want.status) begin
                  report_mismatch($sformatf("status %0d, expected %0d (cp %0h)",
                                            rsp_tuser, want.status, want.code_point));
               end
               if (rsp_tlast !== want.end_of_string) begin
                  report_mismatch($sformatf("end of string %0b, expected %0b (cp %0h)",
                                            rsp_tlast, want.end_of_string,
                                            want.code_point));
               end
            end
         end
      end
      mismatch_count <= mismatches;
      results_due <= chars_due.size();
   end

endmodule

@@ bench/utf8_byte_stream_decoder_core_test.sv @@
`timescale 1ns / 100ps
// Testbench top for the UTF-8 byte stream decoder: sends directed and random
// strings in bursts, stalls the result side, and gives the verdict.
// Depends on u8dec_pkg, utf8_byte_stream_decoder_core and utf8_decode_checker.
module utf8_byte_stream_decoder_core_test;

   localparam int RANDOM_BYTES = 1400;
   localparam int HOLD_AFTER   = 500;   // requests sent before the long stall
   localparam int HOLD_CYCLES  = 400;

   // {is_last_byte, data_byte}: ASCII extremes, longest well-formed forms,
   // malformed lead, bad continuation, stray continuation with dropped tail,
   // truncation after a continuation and on a lead, stray continuation as last
   localparam int DIRECTED_COUNT = 24;
   localparam logic [8:0] DIRECTED [DIRECTED_COUNT] = '{
      9'h000, 9'h17F,
      9'h0DF, 9'h0BF,
      9'h0EF, 9'h0BF, 9'h0BF,
      9'h0F7, 9'h0BF, 9'h0BF, 9'h0BF,
      9'h0FF, 9'h080, 9'h080, 9'h080,
      9'h0C3, 9'h041,
      9'h080, 9'h041, 9'h142,
      9'h0E2, 9'h182,
      9'h1C0,
      9'h1BF
   };

   typedef enum int {SINK_OPEN, SINK_COIN, SINK_PERIODIC, SINK_SPARSE} sink_mode_type;

   logic                           clock = 1'b0;
   logic                           reset = 1'b1;
   logic                           req_tvalid = 1'b0;
   logic                           req_tready;
   logic [7:0]                     req_tdata = '0;
   logic                           req_tlast = 1'b0;
   logic                           rsp_tvalid;
   logic                           rsp_tready = 1'b0;
   logic [u8dec_pkg::CP_PAD_W-1:0] rsp_tdata;
   logic [u8dec_pkg::STAT_W-1:0]   rsp_tuser;
   logic                           rsp_tlast;
   int                             mismatch_count;
   int                             results_due;
   int                             bytes_sent = 0;
   int                             burst_left = 0;
   logic [7:0]                     text[$];

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   utf8_byte_stream_decoder_core i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   utf8_decode_checker i_checker (
      .clock          (clock),
      .reset          (reset),
      .req_tvalid     (req_tvalid),
      .req_tready     (req_tready),
      .req_tdata      (req_tdata),
      .req_tlast      (req_tlast),
      .rsp_tvalid     (rsp_tvalid),
      .rsp_tready     (rsp_tready),
      .rsp_tdata      (rsp_tdata),
      .rsp_tuser      (rsp_tuser),
      .rsp_tlast      (rsp_tlast),
      .mismatch_count (mismatch_count),
      .results_due    (results_due)
   );

   // Offer one byte, hold it until taken, then possibly idle if the burst is over
   task automatic send_byte(input logic [7:0] b, input logic last);
      int gap;
      req_tvalid <= 1'b1;
      req_tdata <= b;
      req_tlast <= last;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      bytes_sent++;
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
         burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                                  : $urandom_range(1, 8);
         if (gap > 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
   endtask

   // Build one string, mostly well-formed characters with random payloads
   task automatic build_text();
      int n_chars;
      int kind;
      int len;
      logic [7:0] lead;
      text.delete();
      n_chars = $urandom_range(1, 10);
      repeat (n_chars) begin
         kind = $urandom_range(0, 19);
         if (kind < 8) begin
            len = 0;
            lead = {1'b0, 7'($urandom)};
         end else if (kind < 12) begin
            len = 1;
            lead = {3'b110, 5'($urandom)};
         end else if (kind < 15) begin
            len = 2;
            lead = {4'b1110, 4'($urandom)};
         end else if (kind < 18) begin
            len = 3;
            lead = {5'b11110, 3'($urandom)};
         end else if (kind == 18) begin
            // malformed lead, F8 to FF
            len = 3;
            lead = {5'b11111, 3'($urandom)};
         end else begin
            len = 0;
            lead = 8'($urandom);
         end
         text.push_back(lead);
         repeat (len) begin
            text.push_back(($urandom_range(0, 15) == 0) ? 8'($urandom)
                                                        : {2'b10, 6'($urandom)});
         end
      end
      // cut some strings short, so that they may end inside a character
      if ($urandom_range(0, 5) == 0) begin
         while (text.size() > 1 && $urandom_range(0, 1) == 1) begin
            void'(text.pop_back());
         end
      end
   endtask

   // Stall the result side on changing patterns, with one long hold-off
   initial begin : result_sink
      sink_mode_type mode;
      int left;
      int tick;
      bit held;
      mode = SINK_OPEN;
      left = 0;
      tick = 0;
      held = 1'b0;
      forever begin
         @(posedge clock);
         if (!held && bytes_sent >= HOLD_AFTER) begin
            held = 1'b1;
            rsp_tready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
         end
         if (left == 0) begin
            mode = sink_mode_type'($urandom_range(0, 3));
            left = $urandom_range(16, 96);
         end
         left--;
         tick++;
         case (mode)
            SINK_OPEN: begin
               rsp_tready <= 1'b1;
            end
            SINK_COIN: begin
               rsp_tready <= 1'($urandom_range(0, 1));
            end
            SINK_PERIODIC: begin
               rsp_tready <= (tick % 4) != 0;
            end
            default: begin
               rsp_tready <= ($urandom_range(0, 3) == 0);
            end
         endcase
      end
   end

   // Reset, directed strings, random strings, drain and verdict
   initial begin : stimulus
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      foreach (DIRECTED[i]) begin
         send_byte(DIRECTED[i][7:0], DIRECTED[i][8]);
      end
      while (bytes_sent < DIRECTED_COUNT + RANDOM_BYTES) begin
         build_text();
         foreach (text[i]) begin
            send_byte(text[i], i == text.size() - 1);
         end
      end
      req_tvalid <= 1'b0;
      repeat (4) @(posedge clock);
      while (results_due != 0) @(posedge clock);
      repeat (16) @(posedge clock);
      if (mismatch_count == 0 && results_due == 0) begin
         $display("utf8_byte_stream_decoder_core test passed");
      end else begin
         $display("utf8_byte_stream_decoder_core test failed");
      end
      $finish;
   end

   // Stop a hung run
   initial begin : watchdog
      #5000000;
      $display("utf8_byte_stream_decoder_core test failed");
      $finish;
   end

endmodule

@@ utf8_byte_stream_decoder_core.f @@
+incdir+rtl/core
rtl/core/u8dec_pkg.sv
rtl/core/utf8_byte_stream_decoder_core.sv
rtl/core/u8dec_checker.sv
bench/utf8_decode_checker.sv
bench/utf8_byte_stream_decoder_core_test.sv
